// ===== hdl/rbfo_pkg.sv =====
package rbfo_pkg;

    // Fixed widths of the transfer fields and configuration registers.
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Reset values of the configuration registers.
    localparam logic [CAP_W-1:0] CAP_RESET       = 7'd64;
    localparam logic             OVERWRITE_RESET = 1'b0;

    // Register index as decoded from the word address bit.
    localparam logic REG_CAPACITY  = 1'b0;
    localparam logic REG_OVERWRITE = 1'b1;

    // Request kinds.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One result item.
    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   read_data;
        logic                dropped_oldest;
    } result_t;

endpackage

// ===== hdl/rbfo_store.sv =====
module rbfo_store #(
    parameter int DEPTH        = 64,
    parameter int ELEMENT_BITS = 32,
    parameter int IW           = 6
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [IW-1:0]           waddr,
    input  logic [ELEMENT_BITS-1:0] wdata,
    input  logic [IW-1:0]           rd_addr,
    output logic [ELEMENT_BITS-1:0] head_data
);

    logic [ELEMENT_BITS-1:0] mem [DEPTH];
    logic [ELEMENT_BITS-1:0] head_reg;

    // Slot write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Prefetch of the entry at the next read index, with forwarding of a
    // write that lands in the same slot on the same edge.
    always_ff @(posedge clk)
    begin
        if (we && (waddr == rd_addr))
        begin
            head_reg <= wdata;
        end
        else
        begin
            head_reg <= mem[rd_addr];
        end
    end

    assign head_data = head_reg;

endmodule

// ===== hdl/rbfo_ctrl.sv =====
module rbfo_ctrl #(
    parameter int DEPTH        = 64,
    parameter int ELEMENT_BITS = 32,
    parameter int IW           = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        req_type,
    input  logic [rbfo_pkg::CAP_W-1:0]  capacity_slots,
    input  logic                        overwrite_mode,
    input  logic [ELEMENT_BITS-1:0]     head_data,
    output logic                        we,
    output logic [IW-1:0]               waddr,
    output logic [IW-1:0]               rd_next,
    output rbfo_pkg::result_t           result
);

    localparam int DW = $clog2(DEPTH + 1);
    localparam int SW = (DW > rbfo_pkg::CAP_W) ? DW : rbfo_pkg::CAP_W;

    logic [IW-1:0] rd_idx_reg;
    logic [IW-1:0] rd_idx_next;
    logic [IW-1:0] wr_idx_reg;
    logic [IW-1:0] wr_idx_next;
    logic [SW-1:0] cap_ext;
    logic [SW-1:0] eff_slots;
    logic [IW-1:0] adv_rd;
    logic [IW-1:0] adv_wr;
    logic          empty;
    logic          full;

    // Step an index by one, wrapping at the slot count in use.
    function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx,
                                              input logic [SW-1:0] slots);
        logic [SW-1:0] n;
        n = SW'(idx) + SW'(1);
        if (n >= slots)
        begin
            return '0;
        end
        return n[IW-1:0];
    endfunction

    // Slot count in use, saturated to the range of two up to the depth.
    always_comb
    begin
        cap_ext = SW'(capacity_slots);
        if (cap_ext < SW'(2))
        begin
            eff_slots = SW'(2);
        end
        else if (cap_ext > SW'(DEPTH))
        begin
            eff_slots = SW'(DEPTH);
        end
        else
        begin
            eff_slots = cap_ext;
        end
    end

    // Ring occupancy.
    assign adv_rd = advance(rd_idx_reg, eff_slots);
    assign adv_wr = advance(wr_idx_reg, eff_slots);
    assign empty  = (rd_idx_reg == wr_idx_reg);
    assign full   = (adv_wr == rd_idx_reg);

    // Request handling: index updates, store write and result.
    always_comb
    begin
        rd_idx_next           = rd_idx_reg;
        wr_idx_next           = wr_idx_reg;
        we                    = 1'b0;
        result.status         = rbfo_pkg::ST_OK;
        result.read_data      = '0;
        result.dropped_oldest = 1'b0;
        if (req_type == rbfo_pkg::REQ_READ)
        begin
            if (empty)
            begin
                result.status = rbfo_pkg::ST_EMPTY;
            end
            else
            begin
                result.read_data = rbfo_pkg::DATA_W'(head_data);
                rd_idx_next      = accept ? adv_rd : rd_idx_reg;
            end
        end
        else
        begin
            if (full && !overwrite_mode)
            begin
                result.status = rbfo_pkg::ST_FULL;
            end
            else
            begin
                if (full)
                begin
                    result.dropped_oldest = 1'b1;
                    rd_idx_next           = accept ? adv_rd : rd_idx_reg;
                end
                we          = accept;
                wr_idx_next = accept ? adv_wr : wr_idx_reg;
            end
        end
    end

    assign waddr   = wr_idx_reg;
    assign rd_next = rd_idx_next;

    // Read and write indices.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
        end
    end

    // A refused write must leave the write index alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == rbfo_pkg::REQ_WRITE && full && !overwrite_mode)
        |=> $stable(wr_idx_reg))
    else $error("write index moved on a refused write");

    // A read of an empty ring must leave the read index alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == rbfo_pkg::REQ_READ && empty)
        |=> $stable(rd_idx_reg))
    else $error("read index moved on an empty read");

    // A drop only happens on a write to a full ring in overwrite mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.dropped_oldest)
        |-> (req_type == rbfo_pkg::REQ_WRITE && full && overwrite_mode))
    else $error("oldest entry dropped without a full overwrite");

endmodule

// ===== hdl/rbfo_outbuf.sv =====
module rbfo_outbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rbfo_pkg::result_t in_result,
    output logic              out_valid,
    input  logic              out_stall,
    output rbfo_pkg::result_t out_result
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    rbfo_pkg::result_t out_data_reg;
    rbfo_pkg::result_t skid_data_reg;
    logic              accept;
    logic              out_move;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_move = !out_valid_reg || !out_stall;

    // Valid flags of the output register and the skid entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_move)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payloads.
    always_ff @(posedge clk)
    begin
        if (out_move)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (accept)
            begin
                out_data_reg <= in_result;
            end
        end
        else if (accept)
        begin
            skid_data_reg <= in_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_data_reg;

    // The skid entry is only used behind a held output transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
    else $error("skid entry held while output register is empty");

    // A transfer taken while the output is stalled lands in the skid entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg && out_stall) |=> skid_valid_reg)
    else $error("transfer lost behind a stalled output");

    // A pending skid entry moves forward as soon as the output drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (out_valid_reg && !skid_valid_reg))
    else $error("skid entry not forwarded after the output drained");

endmodule

// ===== hdl/ring_buffer_fifo_overwrite.sv =====
// Circular FIFO with an optional overwrite of the oldest entry.
// Request channel: in_valid / in_stall with req_type (read or write) and
// write_data. Result channel: out_valid / out_stall with status, read_data
// and dropped_oldest; every accepted request yields exactly one result.
// Registers on the APB port: capacity_slots at byte address 0 and
// overwrite_mode at byte address 4. Write them only while the block is idle.
// Each result is registered before it is offered. Throughput is one request
// per cycle while in_stall is low, set by the single slot memory whose read
// port prefetches the entry at the next read index every cycle.
// The ring holds at most the slot count in use minus one entries.
// Reset clears both indices, sets capacity_slots to 64, turns overwrite off
// and empties the output buffer; the slot memory is not cleared.
// When the receiver stalls, the current result is held and one more result
// goes into a skid entry; in_stall rises only while that entry is occupied.
module ring_buffer_fifo_overwrite #(
    parameter int DEPTH        = 64,
    parameter int ELEMENT_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             req_type,
    input  logic [rbfo_pkg::DATA_W-1:0]      write_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       status,
    output logic [rbfo_pkg::DATA_W-1:0]      read_data,
    output logic                             dropped_oldest,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rbfo_pkg::PADDR_W-1:0]     paddr,
    input  logic [rbfo_pkg::PDATA_W-1:0]     pwdata,
    output logic [rbfo_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam int IW = $clog2(DEPTH);

    logic [rbfo_pkg::CAP_W-1:0] cap_reg;
    logic                       overwrite_reg;
    logic                       cfg_write;
    logic                       accept;
    logic                       we;
    logic [IW-1:0]              waddr;
    logic [IW-1:0]              rd_next;
    logic [ELEMENT_BITS-1:0]    head_data;
    logic [ELEMENT_BITS-1:0]    store_wdata;
    rbfo_pkg::result_t          step_result;
    rbfo_pkg::result_t          out_result;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= rbfo_pkg::CAP_RESET;
            overwrite_reg <= rbfo_pkg::OVERWRITE_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                rbfo_pkg::REG_CAPACITY:  cap_reg       <= pwdata[rbfo_pkg::CAP_W-1:0];
                rbfo_pkg::REG_OVERWRITE: overwrite_reg <= pwdata[0];
                default:                 cap_reg       <= cap_reg;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (paddr[2])
            rbfo_pkg::REG_CAPACITY:  prdata = rbfo_pkg::PDATA_W'(cap_reg);
            rbfo_pkg::REG_OVERWRITE: prdata = rbfo_pkg::PDATA_W'(overwrite_reg);
            default:                 prdata = '0;
        endcase
    end

    // Request transfer.
    assign accept      = in_valid && !in_stall;
    assign store_wdata = ELEMENT_BITS'(write_data);

    rbfo_ctrl #(
        .DEPTH        (DEPTH),
        .ELEMENT_BITS (ELEMENT_BITS),
        .IW           (IW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .req_type       (req_type),
        .capacity_slots (cap_reg),
        .overwrite_mode (overwrite_reg),
        .head_data      (head_data),
        .we             (we),
        .waddr          (waddr),
        .rd_next        (rd_next),
        .result         (step_result)
    );

    rbfo_store #(
        .DEPTH        (DEPTH),
        .ELEMENT_BITS (ELEMENT_BITS),
        .IW           (IW)
    ) u_store (
        .clk       (clk),
        .we        (we),
        .waddr     (waddr),
        .wdata     (store_wdata),
        .rd_addr   (rd_next),
        .head_data (head_data)
    );

    rbfo_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_result  (step_result),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    // Result fields.
    assign status         = out_result.status;
    assign read_data      = out_result.read_data;
    assign dropped_oldest = out_result.dropped_oldest;

endmodule

// ===== tb/tb_ring_buffer_fifo_overwrite.sv =====
`timescale 1ns / 1ps

module tb_ring_buffer_fifo_overwrite;

    localparam int SLOT_LIMIT     = 64;
    localparam int MAX_IDLE       = 13;
    localparam int LONG_HOLD      = 160;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 82;

    // Kinds of rows in the directed stimulus table.
    typedef enum logic [1:0] {
        ROW_REQUEST,
        ROW_CAPACITY,
        ROW_OVERWRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic                        req;
        logic [rbfo_pkg::DATA_W-1:0] value;
        logic                        typed;
        rbfo_pkg::result_t           want;
    } stim_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic                         req_type;
    logic [rbfo_pkg::DATA_W-1:0]  write_data;
    logic                         out_valid;
    logic                         out_stall;
    logic [1:0]                   status;
    logic [rbfo_pkg::DATA_W-1:0]  read_data;
    logic                         dropped_oldest;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [rbfo_pkg::PADDR_W-1:0] paddr;
    logic [rbfo_pkg::PDATA_W-1:0] pwdata;
    logic [rbfo_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    // Typed expectation that travels with the current request.
    logic                         row_typed;
    rbfo_pkg::result_t            row_want;

    // Predicted state of the ring.
    logic [rbfo_pkg::DATA_W-1:0]  slot_mem [0:SLOT_LIMIT-1];
    int                           rd_idx;
    int                           wr_idx;
    logic [rbfo_pkg::CAP_W-1:0]   cap_reg;
    logic                         ovw_reg;

    rbfo_pkg::result_t            awaited_results [$];
    stim_row_t                    directed_rows [$];
    int                           mismatch_count = 0;
    bit                           tx_steady = 1'b0;
    bit                           rx_steady = 1'b0;
    bit                           long_hold_req = 1'b0;

    int phase_cap [0:PHASES-1] = '{3, 64, 5, 1, 17, 8, 100, 2, 64, 33, 6, 127};
    bit phase_ovw [0:PHASES-1] = '{0, 1, 1, 0, 0, 1, 1, 1, 0, 0, 1, 0};

    wire apb_write   = psel && penable && pwrite && pready;
    wire req_xfer    = in_valid && !in_stall;
    wire result_xfer = out_valid && !out_stall;

    ring_buffer_fifo_overwrite i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_data      (read_data),
        .dropped_oldest (dropped_oldest),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The slot count in use is the capacity register saturated to 2 .. 64.
    function automatic int ring_slots();
        int c;
        c = int'(cap_reg);
        if (c < 2)
            c = 2;
        if (c > SLOT_LIMIT)
            c = SLOT_LIMIT;
        return c;
    endfunction

    // An index wraps to zero once it reaches the slot count, even from beyond it.
    function automatic int ring_next(input int idx);
        return (idx + 1 >= ring_slots()) ? 0 : idx + 1;
    endfunction

    // Applies one request to the predicted ring and returns its status result.
    function automatic rbfo_pkg::result_t fifo_step(input logic rt,
                                                    input logic [rbfo_pkg::DATA_W-1:0] d);
        rbfo_pkg::result_t r;
        logic              full;
        r.status         = rbfo_pkg::ST_OK;
        r.read_data      = '0;
        r.dropped_oldest = 1'b0;
        if (rt == rbfo_pkg::REQ_READ)
        begin
            if (rd_idx == wr_idx)
                r.status = rbfo_pkg::ST_EMPTY;
            else
            begin
                r.read_data = slot_mem[rd_idx];
                rd_idx      = ring_next(rd_idx);
            end
        end
        else
        begin
            full = (ring_next(wr_idx) == rd_idx);
            if (full && !ovw_reg)
                r.status = rbfo_pkg::ST_FULL;
            else
            begin
                if (full)
                begin
                    rd_idx           = ring_next(rd_idx);
                    r.dropped_oldest = 1'b1;
                end
                slot_mem[wr_idx] = d;
                wr_idx           = ring_next(wr_idx);
            end
        end
        return r;
    endfunction

    function automatic stim_row_t stim_row(input row_kind_t kind, input logic req,
                                           input logic [rbfo_pkg::DATA_W-1:0] value,
                                           input logic typed,
                                           input rbfo_pkg::status_t st,
                                           input logic [rbfo_pkg::DATA_W-1:0] rd,
                                           input logic drop);
        stim_row_t s;
        s.kind                = kind;
        s.req                 = req;
        s.value               = value;
        s.typed               = typed;
        s.want.status         = st;
        s.want.read_data      = rd;
        s.want.dropped_oldest = drop;
        return s;
    endfunction

    // Mostly random words, with zeros, all ones and single set bits mixed in.
    function automatic logic [rbfo_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // Offers one request after a random gap and returns at the edge that takes it.
    task automatic send_request(input logic rt, input logic [rbfo_pkg::DATA_W-1:0] d,
                                input logic typed, input rbfo_pkg::result_t want);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rt;
        write_data <= d;
        row_typed  <= typed;
        row_want   <= want;
        do @(posedge clk); while (in_stall);
    endtask

    // Stops offering requests and waits until every awaited result has come back.
    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [rbfo_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // The ring is emptied before its size changes, so no read ever reaches
    // a slot that was never written.
    task automatic resize_ring(input int slots_req);
        int backlog;
        int idx;
        settle_idle();
        backlog = 0;
        idx     = rd_idx;
        while (idx != wr_idx && backlog < 4 * SLOT_LIMIT)
        begin
            idx = ring_next(idx);
            backlog++;
        end
        if (backlog > 0)
        begin
            repeat (backlog) send_request(rbfo_pkg::REQ_READ, '0, 1'b0, '0);
            settle_idle();
        end
        write_register(rbfo_pkg::REG_CAPACITY, rbfo_pkg::PDATA_W'(slots_req));
    endtask

    // Checks each result transfer, predicts each request transfer and
    // follows register writes.
    always @(posedge clk)
    begin : scoreboard
        rbfo_pkg::result_t want;
        rbfo_pkg::result_t got;
        if (rst_n)
        begin
            if (result_xfer)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result transfer with no result awaited (status %0d)",
                             $time, status);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, status);
                        mismatch_count++;
                    end
                    if (read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %h, actual %h",
                                 $time, want.read_data, read_data);
                        mismatch_count++;
                    end
                    if (dropped_oldest !== want.dropped_oldest)
                    begin
                        $display("%0t: dropped_oldest expected %0b, actual %0b",
                                 $time, want.dropped_oldest, dropped_oldest);
                        mismatch_count++;
                    end
                end
            end
            if (req_xfer)
            begin
                got = fifo_step(req_type, write_data);
                awaited_results.push_back(row_typed ? row_want : got);
            end
            if (apb_write)
            begin
                if (paddr[2] == rbfo_pkg::REG_OVERWRITE)
                    ovw_reg = pwdata[0];
                else
                    cap_reg = pwdata[rbfo_pkg::CAP_W-1:0];
            end
        end
    end

    // Result receiver: random stalls per transfer, steady stretches, and one
    // long hold-off when asked for.
    initial
    begin : result_receiver
        int hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            hold = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (req_xfer || result_xfer || apb_write)
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int  p;
        int  slots;
        int  sent;
        int  run;
        int  mode;
        int  k;
        logic rt;

        rst_n      = 1'b0;
        in_valid   <= 1'b0;
        req_type   <= rbfo_pkg::REQ_READ;
        write_data <= '0;
        row_typed  <= 1'b0;
        row_want   <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        rd_idx     = 0;
        wr_idx     = 0;
        cap_reg    = rbfo_pkg::CAP_RESET;
        ovw_reg    = rbfo_pkg::OVERWRITE_RESET;
        foreach (slot_mem[i])
            slot_mem[i] = '0;

        // Directed table: reset state, field extremes, refused write, overwrite
        // drop, capacity saturation at both ends. After the shrink to two
        // slots both indices sit past the slot count and wrap on their own.
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_READ, 32'h0, 1'b1,
                                         rbfo_pkg::ST_EMPTY, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_WRITE, 32'h0, 1'b1,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_WRITE, '1, 1'b1,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_WRITE, 32'h5A5AA5A5, 1'b0,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_READ, '1, 1'b1,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_READ, 32'h0, 1'b1,
                                         rbfo_pkg::ST_OK, '1, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_READ, 32'h0, 1'b0,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_READ, 32'h0, 1'b1,
                                         rbfo_pkg::ST_EMPTY, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_CAPACITY, rbfo_pkg::REQ_READ, 32'd2, 1'b0,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_WRITE, 32'h80000001, 1'b1,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_WRITE, 32'h1, 1'b1,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_READ, 32'h0, 1'b1,
                                         rbfo_pkg::ST_OK, 32'h80000001, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_READ, 32'h0, 1'b1,
                                         rbfo_pkg::ST_OK, 32'h1, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_WRITE, 32'h0000FFFF, 1'b1,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_WRITE, 32'h1, 1'b1,
                                         rbfo_pkg::ST_FULL, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_READ, 32'h0, 1'b1,
                                         rbfo_pkg::ST_OK, 32'h0000FFFF, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_READ, 32'h0, 1'b1,
                                         rbfo_pkg::ST_EMPTY, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_OVERWRITE, rbfo_pkg::REQ_READ, 32'd1, 1'b0,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_WRITE, 32'h13579BDF, 1'b0,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_WRITE, 32'h2468ACE0, 1'b1,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b1));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_READ, 32'h0, 1'b1,
                                         rbfo_pkg::ST_OK, 32'h2468ACE0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_READ, 32'h0, 1'b1,
                                         rbfo_pkg::ST_EMPTY, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_CAPACITY, rbfo_pkg::REQ_READ, 32'd0, 1'b0,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_WRITE, 32'h0F0F0F0F, 1'b0,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_WRITE, 32'h00FF00FF, 1'b1,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b1));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_READ, 32'h0, 1'b1,
                                         rbfo_pkg::ST_OK, 32'h00FF00FF, 1'b0));
        directed_rows.push_back(stim_row(ROW_CAPACITY, rbfo_pkg::REQ_READ, 32'd127, 1'b0,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_OVERWRITE, rbfo_pkg::REQ_READ, 32'd0, 1'b0,
                                         rbfo_pkg::ST_OK, 32'h0, 1'b0));
        directed_rows.push_back(stim_row(ROW_REQUEST, rbfo_pkg::REQ_READ, 32'h0, 1'b1,
                                         rbfo_pkg::ST_EMPTY, 32'h0, 1'b0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_CAPACITY:
                    resize_ring(int'(directed_rows[i].value));
                ROW_OVERWRITE:
                begin
                    settle_idle();
                    write_register(rbfo_pkg::REG_OVERWRITE, directed_rows[i].value);
                end
                default:
                    send_request(directed_rows[i].req, directed_rows[i].value,
                                 directed_rows[i].typed, directed_rows[i].want);
            endcase
        end

        // Random phases: each one sets both registers, then runs bursts of
        // writes and reads long enough to reach full and empty.
        for (p = 0; p < PHASES; p++)
        begin
            resize_ring(phase_cap[p]);
            write_register(rbfo_pkg::REG_OVERWRITE, rbfo_pkg::PDATA_W'(phase_ovw[p]));
            slots = phase_cap[p];
            if (slots < 2)
                slots = 2;
            if (slots > SLOT_LIMIT)
                slots = SLOT_LIMIT;
            tx_steady = ($urandom_range(0, 2) == 0);
            // Hold the receiver off while requests keep coming, to fill the block.
            if (p == 1 || p == 8)
            begin
                tx_steady     = 1'b1;
                long_hold_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                run  = $urandom_range(1, slots + 2);
                mode = $urandom_range(0, 3);
                for (k = 0; k < run && sent < PHASE_ITEMS; k++)
                begin
                    case (mode)
                        0: rt = ($urandom_range(0, 7) != 0) ? rbfo_pkg::REQ_WRITE
                                                            : rbfo_pkg::REQ_READ;
                        1: rt = ($urandom_range(0, 7) != 0) ? rbfo_pkg::REQ_READ
                                                            : rbfo_pkg::REQ_WRITE;
                        2: rt = (k % 2 == 0) ? rbfo_pkg::REQ_WRITE : rbfo_pkg::REQ_READ;
                        default: rt = $urandom_range(0, 1) ? rbfo_pkg::REQ_WRITE
                                                           : rbfo_pkg::REQ_READ;
                    endcase
                    send_request(rt, pick_word(), 1'b0, '0);
                    sent++;
                end
            end
        end

        settle_idle();
        repeat (5) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
